### sv/gh3_pkg.sv
// shared types and codes for the 3d gilbert curve index/cell converter
`default_nettype none
package gh3_pkg;

    // configuration register width and indexes
    localparam int CFG_W = 11;
    localparam logic [1:0] CFG_GRID_X = 2'd0;
    localparam logic [1:0] CFG_GRID_Y = 2'd1;
    localparam logic [1:0] CFG_GRID_Z = 2'd2;

    // opcodes
    localparam logic OP_INDEX_TO_CELL = 1'b0;
    localparam logic OP_CELL_TO_INDEX = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_INDEX = 2'd1;
    localparam logic [1:0] STAT_CELL  = 2'd2;

    // input beat
    typedef struct packed {
        logic        opcode;
        logic [29:0] curve_index;
        logic [9:0]  cell_x;
        logic [9:0]  cell_y;
        logic [9:0]  cell_z;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [29:0] out_index;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [9:0]  out_z;
        logic [1:0]  status;
    } t_out_beat;

endpackage
`default_nettype wire

### sv/gh3_frame_mem.sv
// frame stack memory: one write port, one registered read port
`default_nettype none
module gh3_frame_mem #(
    parameter int DEPTH = 40,
    parameter int W = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/gh3_split.sv
// box subdivision: child count and the selected child box of a parent
`default_nettype none
module gh3_split #(
    parameter int CW = 12
) (
    input  wire logic [2:0][CW-1:0] i_s,
    input  wire logic [2:0][CW-1:0] i_a,
    input  wire logic [2:0][CW-1:0] i_b,
    input  wire logic [2:0][CW-1:0] i_c,
    input  wire logic [2:0]         i_child,
    output logic [2:0]              o_num,
    output logic [2:0][CW-1:0]      o_s,
    output logic [2:0][CW-1:0]      o_a,
    output logic [2:0][CW-1:0]      o_b,
    output logic [2:0][CW-1:0]      o_c
);

    typedef enum logic [1:0] {
        M_TWO, M_THREE_B, M_THREE_C, M_FIVE
    } t_mode;

    function automatic logic signed [CW-1:0] sgn(input logic signed [CW-1:0] v);
        if (v > 0) return CW'(1);
        if (v < 0) return -CW'(1);
        return '0;
    endfunction

    function automatic logic signed [CW+1:0] len3(input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y,
                                                  input logic signed [CW-1:0] z);
        logic signed [CW+1:0] t;
        t = (CW+2)'(x) + (CW+2)'(y) + (CW+2)'(z);
        return (t < 0) ? -t : t;
    endfunction

    logic signed [CW-1:0] sa [3], sb [3], sc [3], ss [3];
    logic signed [CW-1:0] da [3], db [3], dc [3];
    logic signed [CW-1:0] a2 [3], b2 [3], c2 [3];
    logic signed [CW+1:0] w, h, d;
    logic signed [CW+1:0] la2, lb2, lc2;
    logic signed [CW+3:0] w2, h3, h4, d3, d4;
    t_mode mode;

    // halves with the even-step bump
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sa[i] = $signed(i_a[i]);
            sb[i] = $signed(i_b[i]);
            sc[i] = $signed(i_c[i]);
            ss[i] = $signed(i_s[i]);
            da[i] = sgn(sa[i]);
            db[i] = sgn(sb[i]);
            dc[i] = sgn(sc[i]);
        end
        w = len3(sa[0], sa[1], sa[2]);
        h = len3(sb[0], sb[1], sb[2]);
        d = len3(sc[0], sc[1], sc[2]);
        for (int i = 0; i < 3; i++) begin
            a2[i] = sa[i] >>> 1;
            b2[i] = sb[i] >>> 1;
            c2[i] = sc[i] >>> 1;
        end
        la2 = len3(a2[0], a2[1], a2[2]);
        lb2 = len3(b2[0], b2[1], b2[2]);
        lc2 = len3(c2[0], c2[1], c2[2]);
        for (int i = 0; i < 3; i++) begin
            if (la2[0] && w > 2) a2[i] = a2[i] + da[i];
            if (lb2[0] && h > 2) b2[i] = b2[i] + db[i];
            if (lc2[0] && d > 2) c2[i] = c2[i] + dc[i];
        end
    end

    // split shape from the axis lengths
    always_comb begin
        w2 = (CW+4)'(w) <<< 1;
        h3 = (CW+4)'(h) * 3;
        h4 = (CW+4)'(h) <<< 2;
        d3 = (CW+4)'(d) * 3;
        d4 = (CW+4)'(d) <<< 2;
        if (w2 > h3 && w2 > d3) begin
            mode = M_TWO;
        end else if (h3 > d4) begin
            mode = M_THREE_B;
        end else if (d3 > h4) begin
            mode = M_THREE_C;
        end else begin
            mode = M_FIVE;
        end
        unique case (mode)
            M_TWO:               o_num = 3'd2;
            M_THREE_B, M_THREE_C: o_num = 3'd3;
            default:             o_num = 3'd5;
        endcase
    end

    // selected child box
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_s[i] = ss[i];
            o_a[i] = sa[i];
            o_b[i] = sb[i];
            o_c[i] = sc[i];
            unique case (mode)
                M_TWO: begin
                    if (i_child == 3'd0) begin
                        o_a[i] = a2[i];
                    end else begin
                        o_s[i] = ss[i] + a2[i];
                        o_a[i] = sa[i] - a2[i];
                    end
                end
                M_THREE_B: begin
                    priority case (i_child)
                        3'd0: begin
                            o_a[i] = b2[i]; o_b[i] = sc[i]; o_c[i] = a2[i];
                        end
                        3'd1: begin
                            o_s[i] = ss[i] + b2[i]; o_b[i] = sb[i] - b2[i];
                        end
                        default: begin
                            o_s[i] = ss[i] + (sa[i] - da[i]) + (b2[i] - db[i]);
                            o_a[i] = -b2[i]; o_b[i] = sc[i]; o_c[i] = -(sa[i] - a2[i]);
                        end
                    endcase
                end
                M_THREE_C: begin
                    priority case (i_child)
                        3'd0: begin
                            o_a[i] = c2[i]; o_b[i] = a2[i]; o_c[i] = sb[i];
                        end
                        3'd1: begin
                            o_s[i] = ss[i] + c2[i]; o_c[i] = sc[i] - c2[i];
                        end
                        default: begin
                            o_s[i] = ss[i] + (sa[i] - da[i]) + (c2[i] - dc[i]);
                            o_a[i] = -c2[i]; o_b[i] = -(sa[i] - a2[i]); o_c[i] = sb[i];
                        end
                    endcase
                end
                default: begin
                    priority case (i_child)
                        3'd0: begin
                            o_a[i] = b2[i]; o_b[i] = c2[i]; o_c[i] = a2[i];
                        end
                        3'd1: begin
                            o_s[i] = ss[i] + b2[i];
                            o_a[i] = sc[i]; o_b[i] = a2[i]; o_c[i] = sb[i] - b2[i];
                        end
                        3'd2: begin
                            o_s[i] = ss[i] + (b2[i] - db[i]) + (sc[i] - dc[i]);
                            o_b[i] = -b2[i]; o_c[i] = -(sc[i] - c2[i]);
                        end
                        3'd3: begin
                            o_s[i] = ss[i] + (sa[i] - da[i]) + b2[i] + (sc[i] - dc[i]);
                            o_a[i] = -sc[i]; o_b[i] = -(sa[i] - a2[i]);
                            o_c[i] = sb[i] - b2[i];
                        end
                        default: begin
                            o_s[i] = ss[i] + (sa[i] - da[i]) + (b2[i] - db[i]);
                            o_a[i] = -b2[i]; o_b[i] = c2[i]; o_c[i] = -(sa[i] - a2[i]);
                        end
                    endcase
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/gilbert_3d_index_point_convert.sv
// top level: 3d gilbert curve index/cell converter with a frame stack in memory
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | sink      | i_in_valid / o_in_stall   | gh3_pkg::t_in_beat
//  out      | source    | o_out_valid / i_out_stall | gh3_pkg::t_out_beat
//  cfg      | sink      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// one item at a time; a box is evaluated in S_LEN, S_WH, S_VOL and S_DECIDE,
// a frame pop in S_POP and S_SPLIT, and a cell-to-index line walk in S_WALK;
// the time an item takes is set by how deep it descends through the frame stack.
// reset is synchronous, active low; grid registers reset to one cell.
// a result waits in the output register while the next item is already taken.
`default_nettype none
module gilbert_3d_index_point_convert #(
    parameter int MAX_SIDE = 1024,
    parameter int STACK_DEPTH = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire gh3_pkg::t_in_beat i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output gh3_pkg::t_out_beat    o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [gh3_pkg::CFG_W-1:0] i_cfg_data
);
    import gh3_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CW = (SIDE_W + 3 > 12) ? SIDE_W + 3 : 12;
    localparam int VOL_W = 3 * SIDE_W;
    localparam int RI_W = (VOL_W > 31) ? VOL_W : 31;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = 3 + 12 * CW;

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_WH, S_VOL, S_DECIDE, S_WALK, S_POP, S_SPLIT, S_DONE
    } t_state;

    typedef logic [2:0][CW-1:0] t_vec;

    function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] g);
        logic [31:0] gv;
        gv = 32'(g);
        if (gv == 32'd0) begin
            gv = 32'd1;
        end else if (gv > 32'(MAX_SIDE)) begin
            gv = 32'(MAX_SIDE);
        end
        return SIDE_W'(gv);
    endfunction

    function automatic logic [SIDE_W-1:0] len3(input t_vec v);
        logic signed [CW+1:0] t;
        t = (CW+2)'($signed(v[0])) + (CW+2)'($signed(v[1])) + (CW+2)'($signed(v[2]));
        if (t < 0) t = -t;
        return SIDE_W'(t);
    endfunction

    // configuration registers
    logic [CFG_W-1:0] r_gx, r_gy, r_gz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx <= CFG_W'(1);
            r_gy <= CFG_W'(1);
            r_gz <= CFG_W'(1);
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                CFG_GRID_X: r_gx <= i_cfg_data;
                CFG_GRID_Y: r_gy <= i_cfg_data;
                CFG_GRID_Z: r_gz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state;
    logic              r_op;
    logic [29:0]       r_req;
    t_vec              r_pt;
    t_vec              r_s, r_a, r_b, r_c;
    logic [SIDE_W-1:0] r_w, r_h, r_d;
    logic [2*SIDE_W-1:0] r_wh;
    logic [VOL_W-1:0]  r_vol;
    logic [RI_W-1:0]   r_ri;
    logic [SP_W-1:0]   r_sp;
    t_vec              r_pos, r_dir;
    logic [SIDE_W-1:0] r_steps, r_cnt;
    t_out_beat         r_res;
    t_out_beat         r_out;
    logic              r_out_valid;

    // frame stack memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    gh3_frame_mem #(.DEPTH(STACK_DEPTH), .W(EW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // unpack the frame read back
    logic [2:0] top_child;
    t_vec       top_s, top_a, top_b, top_c;
    assign top_child = mem_rdata[EW-1 -: 3];
    assign top_s = mem_rdata[12*CW-1 -: 3*CW];
    assign top_a = mem_rdata[9*CW-1 -: 3*CW];
    assign top_b = mem_rdata[6*CW-1 -: 3*CW];
    assign top_c = mem_rdata[3*CW-1 -: 3*CW];

    // child box of the frame on top
    logic [2:0] kid_num;
    t_vec       kid_s, kid_a, kid_b, kid_c;

    gh3_split #(.CW(CW)) u_split (
        .i_s    (top_s),
        .i_a    (top_a),
        .i_b    (top_b),
        .i_c    (top_c),
        .i_child(top_child),
        .o_num  (kid_num),
        .o_s    (kid_s),
        .o_a    (kid_a),
        .o_b    (kid_b),
        .o_c    (kid_c)
    );

    // box decision: skip by count or padded bounding box, line case, push
    logic                 bbox_out, skip, is_line, push_ok, kid_left;
    t_vec                 line_ax, line_dir, found;
    logic [SIDE_W-1:0]    line_steps;
    logic [RI_W-1:0]      req_ext, ri_plus;
    logic [CW-1:0]        diff;
    logic signed [CW+2:0] adv, bnd, lo, hi, sv, pv;
    logic [AW-1:0]        top_idx;

    always_comb begin
        bbox_out = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sv  = (CW+3)'($signed(r_s[i]));
            adv = (CW+3)'($signed(r_a[i])) + (CW+3)'($signed(r_b[i]))
                + (CW+3)'($signed(r_c[i]));
            bnd = sv + adv + ((adv >= 0) ? (CW+3)'(1) : '0);
            lo  = ((sv < bnd) ? sv : bnd) - 1;
            hi  = ((sv > bnd) ? sv : bnd) + 1;
            pv  = (CW+3)'($signed(r_pt[i]));
            if (pv < lo || pv > hi) bbox_out = 1'b1;
        end
        req_ext = RI_W'(r_req);
        ri_plus = r_ri + RI_W'(r_vol);
        skip = (r_vol == '0) ||
               ((r_op == OP_INDEX_TO_CELL) ? (req_ext >= ri_plus) : bbox_out);
        is_line = (r_h == SIDE_W'(1) && r_d == SIDE_W'(1)) ||
                  (r_w == SIDE_W'(1) && r_d == SIDE_W'(1)) ||
                  (r_w == SIDE_W'(1) && r_h == SIDE_W'(1));
        if (r_h == SIDE_W'(1) && r_d == SIDE_W'(1)) begin
            line_ax = r_a; line_steps = r_w;
        end else if (r_w == SIDE_W'(1) && r_d == SIDE_W'(1)) begin
            line_ax = r_b; line_steps = r_h;
        end else begin
            line_ax = r_c; line_steps = r_d;
        end
        diff = CW'(req_ext - r_ri);
        for (int i = 0; i < 3; i++) begin
            if ($signed(line_ax[i]) > 0) begin
                line_dir[i] = CW'(1);
                found[i] = r_s[i] + diff;
            end else if ($signed(line_ax[i]) < 0) begin
                line_dir[i] = -CW'(1);
                found[i] = r_s[i] - diff;
            end else begin
                line_dir[i] = '0;
                found[i] = r_s[i];
            end
        end
        push_ok = r_sp < SP_W'(STACK_DEPTH);
        top_idx = AW'(r_sp - SP_W'(1));
        kid_left = top_child < kid_num;
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(r_sp);
        mem_wdata = {3'd0, r_s, r_a, r_b, r_c};
        mem_raddr = top_idx;
        if (r_state == S_DECIDE && !skip && !is_line && push_ok) begin
            mem_we = 1'b1;
        end else if (r_state == S_SPLIT && kid_left) begin
            mem_we    = 1'b1;
            mem_waddr = top_idx;
            mem_wdata = {top_child + 3'd1, top_s, top_a, top_b, top_c};
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
            r_ri        <= '0;
        end else begin
            // output register: load from the finished item, drop on accept
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op  <= i_in_data.opcode;
                        r_req <= i_in_data.curve_index;
                        r_pt  <= {CW'(i_in_data.cell_z), CW'(i_in_data.cell_y),
                                  CW'(i_in_data.cell_x)};
                        r_s <= '0;
                        r_a <= {{(2*CW){1'b0}}, CW'(eff_side(r_gx))};
                        r_b <= {CW'(0), CW'(eff_side(r_gy)), CW'(0)};
                        r_c <= {CW'(eff_side(r_gz)), {(2*CW){1'b0}}};
                        r_ri <= '0;
                        r_sp <= '0;
                        if (i_in_data.opcode == OP_CELL_TO_INDEX &&
                            (SIDE_W'(i_in_data.cell_x) >= eff_side(r_gx) ||
                             SIDE_W'(i_in_data.cell_y) >= eff_side(r_gy) ||
                             SIDE_W'(i_in_data.cell_z) >= eff_side(r_gz) ||
                             (SIDE_W < 10 && (32'(i_in_data.cell_x) >= 32'(MAX_SIDE) ||
                                              32'(i_in_data.cell_y) >= 32'(MAX_SIDE) ||
                                              32'(i_in_data.cell_z) >= 32'(MAX_SIDE))))) begin
                            r_res <= '{out_index: '0, out_x: '0, out_y: '0, out_z: '0,
                                       status: STAT_CELL};
                            r_state <= S_DONE;
                        end else begin
                            r_res <= '0;
                            r_state <= S_LEN;
                        end
                    end
                end
                S_LEN: begin
                    r_w <= len3(r_a);
                    r_h <= len3(r_b);
                    r_d <= len3(r_c);
                    r_state <= S_WH;
                end
                S_WH: begin
                    r_wh <= (2*SIDE_W)'(r_w) * (2*SIDE_W)'(r_h);
                    r_state <= S_VOL;
                end
                S_VOL: begin
                    r_vol <= VOL_W'(r_wh) * VOL_W'(r_d);
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (skip) begin
                        r_ri <= ri_plus;
                        r_state <= S_POP;
                    end else if (is_line) begin
                        if (r_op == OP_INDEX_TO_CELL) begin
                            r_res <= '{out_index: '0, out_x: found[0][9:0],
                                       out_y: found[1][9:0], out_z: found[2][9:0],
                                       status: STAT_OK};
                            r_state <= S_DONE;
                        end else begin
                            r_pos <= r_s;
                            r_dir <= line_dir;
                            r_steps <= line_steps;
                            r_cnt <= '0;
                            r_state <= S_WALK;
                        end
                    end else if (push_ok) begin
                        r_sp <= r_sp + SP_W'(1);
                        r_state <= S_POP;
                    end else begin
                        r_res <= '{out_index: '0, out_x: '0, out_y: '0, out_z: '0,
                                   status: (r_op == OP_INDEX_TO_CELL) ? STAT_INDEX
                                                                      : STAT_CELL};
                        r_state <= S_DONE;
                    end
                end
                S_WALK: begin
                    if (r_pos == r_pt) begin
                        r_res <= '{out_index: r_ri[29:0], out_x: '0, out_y: '0, out_z: '0,
                                   status: STAT_OK};
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= {r_pos[2] + r_dir[2], r_pos[1] + r_dir[1],
                                  r_pos[0] + r_dir[0]};
                        r_ri <= r_ri + RI_W'(1);
                        r_cnt <= r_cnt + SIDE_W'(1);
                        if (r_cnt == r_steps - SIDE_W'(1)) r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_res <= '{out_index: '0, out_x: '0, out_y: '0, out_z: '0,
                                   status: (r_op == OP_INDEX_TO_CELL) ? STAT_INDEX
                                                                      : STAT_CELL};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (kid_left) begin
                        r_s <= kid_s;
                        r_a <= kid_a;
                        r_b <= kid_b;
                        r_c <= kid_c;
                        r_state <= S_LEN;
                    end else begin
                        r_sp <= r_sp - SP_W'(1);
                        r_state <= S_POP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/gh3_checker.sv
// port-level checks on the converter, bound to the top level
`default_nettype none
module gh3_props (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire gh3_pkg::t_out_beat o_out_data
);
    import gh3_pkg::*;

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed under stall");

    // status is one of the three codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STAT_OK || o_out_data.status == STAT_INDEX
                         || o_out_data.status == STAT_CELL))
        else $error("bad status code");

    // an error beat carries only the status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != STAT_OK) |->
        (o_out_data.out_index == '0 && o_out_data.out_x == '0 &&
         o_out_data.out_y == '0 && o_out_data.out_z == '0))
        else $error("error beat with nonzero fields");

    // a new result never appears without an input having been taken
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

endmodule

bind gilbert_3d_index_point_convert gh3_props u_gh3_props (.*);
`default_nettype wire
